>>> rtl/svc_pkg.sv
// Shared constants and types for the strided valid 2D convolution block.
package svc_pkg;

  localparam int unsigned DEF_MAX_IMAGE  = 1024;
  localparam int unsigned DEF_MAX_KERNEL = 7;

  localparam int unsigned PIX_W  = 16;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned KSZ_W  = 3;
  localparam int unsigned STR_W  = 3;
  localparam int unsigned IMG_W  = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CIDX_W = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_KERNEL = 2'd0;
  localparam logic [CIDX_W-1:0] REG_STRIDE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_IMAGE  = 2'd2;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic wr_weight;
    logic wr_pixel;
    logic acc_clr;
    logic acc_en;
    logic load_out;
  } svc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fire;
    logic mac_last;
  } svc_sts_t;

endpackage

>>> rtl/strided_valid_conv2d.sv
// Top level of the strided valid 2D convolution block.
// A pixel that closes a window moves the controller through the read, MAC and output states;
// out_valid rises once the result is loaded. Weights and non-closing pixels are taken while idle,
// and in_ready stays low while the single multiply-accumulate walks the window one tap per cycle.
// Reset: synchronous active-low; registers return to kernel 3, stride 1, image 1024,
// counters to row 0 column 0; weight and line memories are not cleared.
module strided_valid_conv2d #(
  parameter int unsigned MAX_IMAGE  = svc_pkg::DEF_MAX_IMAGE,
  parameter int unsigned MAX_KERNEL = svc_pkg::DEF_MAX_KERNEL
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [svc_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [svc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [2:0]                        in_weight_row,
  input  logic [2:0]                        in_weight_col,
  input  logic signed [svc_pkg::PIX_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [svc_pkg::ACC_W-1:0]  out_value,
  output logic [svc_pkg::IDX_W-1:0]         out_row,
  output logic [svc_pkg::IDX_W-1:0]         out_col,
  output logic                              out_last
);
  import svc_pkg::*;

  svc_cmd_t cmd;
  svc_sts_t sts;

  svc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode,
    .out_valid, .out_ready, .sts, .cmd
  );

  svc_dp #(.MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_weight_row, .in_weight_col, .in_value,
    .cmd, .sts, .out_valid, .out_ready,
    .out_value, .out_row, .out_col, .out_last
  );
endmodule

>>> rtl/svc_ctrl.sv
// Controller state machine: sequences weight load, pixel store and window MAC.
module svc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_opcode,
  input  logic            out_valid,
  input  logic            out_ready,
  input  svc_pkg::svc_sts_t sts,
  output svc_pkg::svc_cmd_t cmd
);
  import svc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer;

  // accept only while idle; a pending result may still wait downstream
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_opcode == OP_WEIGHT) begin
            cmd.wr_weight = 1'b1;
          end else begin
            cmd.wr_pixel = 1'b1;
            if (sts.fire) begin
              cmd.acc_clr = 1'b1;
              state_nxt   = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        // first memory read is in flight
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.acc_en = 1'b1;
        if (sts.mac_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTH
  a_mac_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_MAC) else $error("read not followed by mac");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready) else $error("accept while busy");
  a_load_leaves_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> state_r == ST_IDLE) else $error("load without return");
`endif
endmodule

>>> rtl/svc_dp.sv
// Datapath: weight store, line store, pixel counters, serial MAC and output reg.
module svc_dp #(
  parameter int unsigned MAX_IMAGE  = svc_pkg::DEF_MAX_IMAGE,
  parameter int unsigned MAX_KERNEL = svc_pkg::DEF_MAX_KERNEL
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [svc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [svc_pkg::CFG_W-1:0]     cfg_data,
  input  logic [2:0]                    in_weight_row,
  input  logic [2:0]                    in_weight_col,
  input  logic signed [svc_pkg::PIX_W-1:0] in_value,
  input  svc_pkg::svc_cmd_t             cmd,
  output svc_pkg::svc_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [svc_pkg::ACC_W-1:0] out_value,
  output logic [svc_pkg::IDX_W-1:0]     out_row,
  output logic [svc_pkg::IDX_W-1:0]     out_col,
  output logic                          out_last
);
  import svc_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_IMAGE + 1);
  localparam int unsigned AW   = $clog2(MAX_IMAGE);
  localparam int unsigned KW   = $clog2(MAX_KERNEL + 1);
  localparam int unsigned KRW  = $clog2(MAX_KERNEL);
  localparam int unsigned WD   = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned WAW  = $clog2(WD);
  localparam int unsigned LD   = MAX_KERNEL * MAX_IMAGE;
  localparam int unsigned LAW  = $clog2(LD);

  // configuration registers
  logic [KSZ_W-1:0] ksz_r;
  logic [STR_W-1:0] str_r;
  logic [IMG_W-1:0] img_r;
  logic [KW-1:0]    k_eff;
  logic [STR_W-1:0] s_eff;
  logic [CW-1:0]    n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksz_r <= KSZ_W'(3);
      str_r <= STR_W'(1);
      img_r <= IMG_W'(1024);
    end else if (cfg_we) begin
      if (cfg_index == REG_KERNEL) ksz_r <= cfg_data[KSZ_W-1:0];
      if (cfg_index == REG_STRIDE) str_r <= cfg_data[STR_W-1:0];
      if (cfg_index == REG_IMAGE)  img_r <= cfg_data[IMG_W-1:0];
    end
  end

  always_comb begin
    if (ksz_r == '0)                        k_eff = KW'(1);
    else if (32'(ksz_r) > MAX_KERNEL)       k_eff = KW'(MAX_KERNEL);
    else                                    k_eff = KW'(ksz_r);
    s_eff = (str_r == '0) ? STR_W'(1) : str_r;
    if (img_r == '0)                        n_eff = CW'(1);
    else if (32'(img_r) > MAX_IMAGE)        n_eff = CW'(MAX_IMAGE);
    else                                    n_eff = CW'(img_r);
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index == REG_KERNEL || cfg_index == REG_STRIDE ||
                              cfg_index == REG_IMAGE);

  // pixel counters plus stride phase and output index counters
  logic [CW-1:0]    row_r, col_r;
  logic [KRW-1:0]   lrow_r;      // row modulo MAX_KERNEL
  logic [STR_W-1:0] rph_r, cph_r; // (r+1-k) mod s once past k-1
  logic [IDX_W-1:0] orow_r, ocol_r;
  logic [CW-1:0]    r_use, c_use;
  logic             wrap_now;
  logic             r_in, c_in;

  assign wrap_now = (col_r >= n_eff) || (row_r >= n_eff);
  assign r_use = wrap_now ? '0 : row_r;
  assign c_use = wrap_now ? '0 : col_r;
  assign r_in  = (32'(r_use) + 1 >= 32'(k_eff));
  assign c_in  = (32'(c_use) + 1 >= 32'(k_eff));

  logic [STR_W-1:0] rph_u, cph_u;
  logic [IDX_W-1:0] orow_u, ocol_u;
  logic [KRW-1:0]   lrow_u;
  assign rph_u  = wrap_now ? '0 : rph_r;
  assign cph_u  = wrap_now ? '0 : cph_r;
  assign orow_u = wrap_now ? '0 : orow_r;
  assign ocol_u = wrap_now ? '0 : ocol_r;
  assign lrow_u = wrap_now ? '0 : lrow_r;

  assign sts.fire = (n_eff >= CW'(k_eff)) && r_in && c_in && rph_u == '0 && cph_u == '0;

  // largest window start, n minus k: the last window is found via index registers instead of a divide
  logic last_win;
  logic [CW-1:0] top_lim;
  assign top_lim  = n_eff - CW'(k_eff);
  // the window is last when another stride would not fit
  assign last_win = (32'(r_use) + 1 - 32'(k_eff) + 32'(s_eff) > 32'(top_lim)) &&
                    (32'(c_use) + 1 - 32'(k_eff) + 32'(s_eff) > 32'(top_lim));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_r <= '0; col_r <= '0; lrow_r <= '0;
      rph_r <= '0; cph_r <= '0; orow_r <= '0; ocol_r <= '0;
    end else if (cmd.wr_pixel) begin
      if (32'(c_use) + 1 >= 32'(n_eff)) begin
        col_r <= '0;
        cph_r <= '0;
        ocol_r <= '0;
        if (32'(r_use) + 1 >= 32'(n_eff)) begin
          row_r <= '0; lrow_r <= '0; rph_r <= '0; orow_r <= '0;
        end else begin
          row_r  <= r_use + CW'(1);
          lrow_r <= (32'(lrow_u) == MAX_KERNEL - 1) ? '0 : lrow_u + KRW'(1);
          if (r_in) begin
            rph_r <= (rph_u == s_eff - STR_W'(1)) ? '0 : rph_u + STR_W'(1);
            if (rph_u == '0) orow_r <= orow_u + IDX_W'(1);
            else             orow_r <= orow_u;
          end else begin
            rph_r <= '0; orow_r <= orow_u;
          end
        end
      end else begin
        col_r <= c_use + CW'(1);
        row_r <= r_use; lrow_r <= lrow_u; rph_r <= rph_u; orow_r <= orow_u;
        if (c_in) begin
          cph_r <= (cph_u == s_eff - STR_W'(1)) ? '0 : cph_u + STR_W'(1);
          ocol_r <= (cph_u == '0) ? ocol_u + IDX_W'(1) : ocol_u;
        end else begin
          cph_r <= '0; ocol_r <= ocol_u;
        end
      end
    end
  end

  // weight memory
  logic [PIX_W-1:0] wmem [WD];
  logic [PIX_W-1:0] wrd_r;
  logic [WAW-1:0]   waddr;

  // line memory
  logic [PIX_W-1:0] lmem [LD];
  logic [PIX_W-1:0] lrd_r;
  logic [LAW-1:0]   lwaddr, lraddr;

  assign lwaddr = LAW'(32'(lrow_u) * MAX_IMAGE + 32'(c_use));

  // window walk: ki, kj and ring row of the tap being read
  logic [KW-1:0]  ki_r, kj_r;
  logic [KRW-1:0] trow_r;
  logic [AW-1:0]  left_r;
  logic           rd_act_r, acc_v_r;

  assign waddr  = WAW'(32'(ki_r) * MAX_KERNEL + 32'(kj_r));
  assign lraddr = LAW'(32'(trow_r) * MAX_IMAGE + 32'(left_r) + 32'(kj_r));

  always_ff @(posedge clk) begin
    if (cmd.wr_weight && 32'(in_weight_row) < MAX_KERNEL && 32'(in_weight_col) < MAX_KERNEL)
      wmem[WAW'(32'(in_weight_row) * MAX_KERNEL + 32'(in_weight_col))] <= in_value;
    wrd_r <= wmem[waddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pixel) lmem[lwaddr] <= in_value;
    lrd_r <= lmem[lraddr];
  end

  // top ring row = (lrow - (k-1)) mod MAX_KERNEL
  logic [KRW-1:0] top_ring;
  always_comb begin
    if (32'(lrow_u) >= 32'(k_eff) - 1) top_ring = KRW'(32'(lrow_u) - 32'(k_eff) + 1);
    else top_ring = KRW'(32'(lrow_u) + MAX_KERNEL - 32'(k_eff) + 1);
  end

  logic rd_last;
  assign rd_last = (ki_r == k_eff - KW'(1)) && (kj_r == k_eff - KW'(1));

  // step through the taps one per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0; acc_v_r <= 1'b0;
      ki_r <= '0; kj_r <= '0; trow_r <= '0; left_r <= '0;
    end else begin
      acc_v_r <= rd_act_r;
      if (cmd.acc_clr) begin
        rd_act_r <= 1'b1;
        ki_r <= '0; kj_r <= '0;
        trow_r <= top_ring;
        left_r <= AW'(32'(c_use) + 1 - 32'(k_eff));
      end else if (rd_act_r) begin
        if (rd_last) begin
          rd_act_r <= 1'b0;
        end else if (kj_r == k_eff - KW'(1)) begin
          kj_r <= '0;
          ki_r <= ki_r + KW'(1);
          trow_r <= (32'(trow_r) == MAX_KERNEL - 1) ? '0 : trow_r + KRW'(1);
        end else begin
          kj_r <= kj_r + KW'(1);
        end
      end
    end
  end

  // registered product then accumulate
  logic signed [2*PIX_W-1:0] prod_r;
  logic                      prod_v_r, prod_last_r, rd_last_r;
  logic signed [ACC_W-1:0]   acc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0; prod_last_r <= 1'b0; rd_last_r <= 1'b0;
    end else begin
      rd_last_r   <= rd_act_r && rd_last;
      prod_v_r    <= acc_v_r;
      prod_last_r <= rd_last_r;
    end
    prod_r <= $signed(lrd_r) * $signed(wrd_r);
    if (cmd.acc_clr)  acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

  assign sts.mac_last = prod_last_r;

  // capture output index at fire time
  logic [IDX_W-1:0] hold_row_r, hold_col_r;
  logic             hold_last_r;
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      hold_row_r  <= orow_u;
      hold_col_r  <= ocol_u;
      hold_last_r <= last_win;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value <= acc_r;
      out_row   <= hold_row_r;
      out_col   <= hold_col_r;
      out_last  <= hold_last_r;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !cmd.load_out |=> out_valid) else $error("result dropped");
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |-> !rd_act_r) else $error("window restarted while reading");
  a_last_once: assert property (@(posedge clk) disable iff (!rst_n)
    prod_last_r |=> !prod_last_r) else $error("double mac end");
`endif
endmodule
